FILE: rtl/evel_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the encoder velocity estimator.
// No dependencies; used by every module under rtl.
package evel_pkg;

   localparam int AngleBits     = 14;
   localparam int AngleFull     = 1 << AngleBits;
   localparam int AngleHalf     = 1 << (AngleBits - 1);
   localparam int VelFracBits   = 8;
   localparam int VelScale      = 1000 * (1 << VelFracBits);
   localparam int DividendBits  = 31;
   localparam int DivSteps      = DividendBits;
   localparam int AlphaBits     = 17;
   localparam int MulSteps      = AlphaBits;
   localparam int DiffBits      = 33;
   localparam int AccBits       = DiffBits + 2;
   localparam int CountBits     = 5;

   typedef logic        [AngleBits-1:0]    angle_type;
   typedef logic signed [AngleBits:0]      delta_type;
   typedef logic        [31:0]             time_type;
   typedef logic signed [31:0]             velocity_type;
   typedef logic        [AlphaBits-1:0]    alpha_type;
   typedef logic        [DividendBits-1:0] dividend_type;
   typedef logic signed [DiffBits-1:0]     diff_type;
   typedef logic        [CountBits-1:0]    count_type;

   localparam delta_type DeltaHalfPos = delta_type'(AngleHalf);
   localparam delta_type DeltaHalfNeg = delta_type'(-AngleHalf);
   localparam delta_type DeltaFull    = delta_type'(AngleFull);

   localparam alpha_type AlphaReset = alpha_type'(13107);
   localparam alpha_type AlphaOne   = alpha_type'(65536);

   localparam logic [2:0] AddrFilterAlpha = 3'd0;

endpackage

FILE: rtl/evel_divider.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on evel_pkg.
module evel_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  evel_pkg::dividend_type dividend,
   input  evel_pkg::time_type    divisor,
   output logic                  done,
   output evel_pkg::dividend_type quotient
);

   logic                   busy_ff;
   logic                   done_ff;
   evel_pkg::count_type    count_ff;
   evel_pkg::time_type     rem_ff;
   evel_pkg::time_type     div_ff;
   evel_pkg::dividend_type quo_ff;

   logic [32:0]            trial;
   logic                   fits;
   logic [32:0]            rem_in;
   logic                   last_step;

   assign trial     = {rem_ff, quo_ff[evel_pkg::DividendBits-1]};
   assign fits      = (trial >= {1'b0, div_ff});
   assign rem_in    = fits ? (trial - {1'b0, div_ff}) : trial;
   assign last_step = (count_ff == evel_pkg::count_type'(evel_pkg::DivSteps - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && !start && last_step;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            rem_ff   <= '0;
            div_ff   <= divisor;
            quo_ff   <= dividend;
         end else if (busy_ff) begin
            rem_ff   <= rem_in[31:0];
            quo_ff   <= {quo_ff[evel_pkg::DividendBits-2:0], fits};
            count_ff <= count_ff + 1'b1;
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/evel_multiplier.sv
`timescale 1ns / 1ps
// Serial shift-add multiplier: floor(alpha * diff / 2^16), one alpha bit per cycle.
// Depends on evel_pkg.
module evel_multiplier (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  evel_pkg::alpha_type    alpha,
   input  evel_pkg::diff_type     diff,
   output logic                   done,
   output evel_pkg::velocity_type step
);

   logic                                busy_ff;
   logic                                done_ff;
   evel_pkg::count_type                 count_ff;
   evel_pkg::alpha_type                 alpha_ff;
   logic signed [evel_pkg::AccBits-1:0] diff_ff;
   logic signed [evel_pkg::AccBits-1:0] acc_ff;

   logic signed [evel_pkg::AccBits-1:0] addend;
   logic signed [evel_pkg::AccBits-1:0] sum;
   logic                                last_step;

   assign last_step = (count_ff == evel_pkg::count_type'(evel_pkg::MulSteps - 1));
   assign addend    = alpha_ff[0] ? diff_ff : '0;
   assign sum       = acc_ff + addend;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && !start && last_step;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            acc_ff   <= '0;
            alpha_ff <= alpha;
            diff_ff  <= {{(evel_pkg::AccBits - evel_pkg::DiffBits){diff[evel_pkg::DiffBits-1]}},
                         diff};
         end else if (busy_ff) begin
            alpha_ff <= alpha_ff >> 1;
            count_ff <= count_ff + 1'b1;
            if (last_step) begin
               acc_ff  <= sum;
               busy_ff <= 1'b0;
            end else begin
               acc_ff <= sum >>> 1;
            end
         end
      end
   end

   assign done = done_ff;
   assign step = acc_ff[31:0];

endmodule

FILE: rtl/encoder_velocity_estimator_top.sv
`timescale 1ns / 1ps
// Encoder velocity estimator top: angle unpack, wrap, serial divide, serial filter.
// Each beat runs S_DIV then S_MUL, or goes straight to S_DONE when the timestamp is unchanged;
// a new beat is accepted only in S_IDLE, so throughput is set by the
// 31-step divider and 17-step multiplier.
// Reset (synchronous, active high) clears stored angle, time, velocity; alpha to 13107.
module encoder_velocity_estimator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_raw_word,
   input  logic [31:0] req_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [13:0] rsp_angle_counts,
   output logic signed [31:0] rsp_velocity,
   output logic        rsp_velocity_updated,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_DONE} state_type;

   state_type              state_ff;
   evel_pkg::alpha_type    alpha_ff;
   evel_pkg::angle_type    last_angle_ff;
   evel_pkg::time_type     last_time_ff;
   evel_pkg::velocity_type fv_ff;
   evel_pkg::angle_type    angle_ff;
   evel_pkg::time_type     now_ff;
   logic                   neg_ff;
   logic                   updated_ff;
   logic                   rsp_valid_ff;
   evel_pkg::angle_type    rsp_angle_ff;
   evel_pkg::velocity_type rsp_velocity_ff;
   logic                   rsp_updated_ff;

   evel_pkg::angle_type    angle_w;
   evel_pkg::time_type     dt_w;
   evel_pkg::delta_type    delta_raw;
   evel_pkg::delta_type    delta_w;
   evel_pkg::delta_type    mag_w;
   evel_pkg::dividend_type num_w;
   logic                   neg_w;
   logic                   accept;
   logic                   csr_write;
   logic                   div_start;
   logic                   div_done;
   evel_pkg::dividend_type div_quotient;
   logic [evel_pkg::DiffBits-1:0] inst_w;
   evel_pkg::diff_type     diff_w;
   evel_pkg::alpha_type    alpha_sat;
   logic                   mul_done;
   evel_pkg::velocity_type mul_step;

   function automatic logic [evel_pkg::DiffBits-1:0] neg_w_sel(
      input logic                          neg,
      input logic [evel_pkg::DiffBits-1:0] val
   );
      neg_w_sel = neg ? (~val + 1'b1) : val;
   endfunction

   // Swap bytes, keep the angle bits.
   assign angle_w   = evel_pkg::angle_type'({req_raw_word[7:0], req_raw_word[15:8]});
   assign dt_w      = req_time_ms - last_time_ff;
   assign delta_raw = evel_pkg::delta_type'({1'b0, angle_w})
                    - evel_pkg::delta_type'({1'b0, last_angle_ff});

   always_comb begin
      delta_w = delta_raw;
      if (delta_raw > evel_pkg::DeltaHalfPos) begin
         delta_w = delta_raw - evel_pkg::DeltaFull;
      end else if (delta_raw < evel_pkg::DeltaHalfNeg) begin
         delta_w = delta_raw + evel_pkg::DeltaFull;
      end
   end

   assign neg_w = delta_w[evel_pkg::AngleBits];
   assign mag_w = neg_w ? -delta_w : delta_w;
   assign num_w = {{(evel_pkg::DividendBits - evel_pkg::AngleBits){1'b0}},
                   mag_w[evel_pkg::AngleBits-1:0]}
                * evel_pkg::dividend_type'(evel_pkg::VelScale);

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign div_start = accept && (dt_w != '0);

   evel_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_w),
      .divisor  (dt_w),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign inst_w    = {2'b00, div_quotient};
   assign diff_w    = evel_pkg::diff_type'(neg_w_sel(neg_ff, inst_w))
                    - evel_pkg::diff_type'({fv_ff[31], fv_ff});
   assign alpha_sat = alpha_ff[evel_pkg::AlphaBits-1] ? evel_pkg::AlphaOne : alpha_ff;

   evel_multiplier u_multiplier (
      .clock (clock),
      .reset (reset),
      .start (div_done),
      .alpha (alpha_sat),
      .diff  (diff_w),
      .done  (mul_done),
      .step  (mul_step)
   );

   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr == evel_pkg::AddrFilterAlpha) ?
                      {{(32 - evel_pkg::AlphaBits){1'b0}}, alpha_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         alpha_ff      <= evel_pkg::AlphaReset;
         last_angle_ff <= '0;
         last_time_ff  <= '0;
         fv_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write && (paddr == evel_pkg::AddrFilterAlpha)) begin
            alpha_ff <= pwdata[evel_pkg::AlphaBits-1:0];
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  angle_ff <= angle_w;
                  now_ff   <= req_time_ms;
                  neg_ff   <= neg_w;
                  if (dt_w == '0) begin
                     updated_ff <= 1'b0;
                     state_ff   <= S_DONE;
                  end else begin
                     updated_ff <= 1'b1;
                     state_ff   <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (mul_done) begin
                  fv_ff         <= fv_ff + mul_step;
                  last_angle_ff <= angle_ff;
                  last_time_ff  <= now_ff;
                  state_ff      <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_angle_ff    <= angle_ff;
                  rsp_velocity_ff <= fv_ff;
                  rsp_updated_ff  <= updated_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_angle_counts     = rsp_angle_ff;
   assign rsp_velocity         = rsp_velocity_ff;
   assign rsp_velocity_updated = rsp_updated_ff;

`ifndef SYNTHESIS
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider done outside divide phase");

   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_MUL))
      else $error("multiplier done outside filter phase");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted beat did not start work");

   a_state_commit: assert property (@(posedge clock) disable iff (reset)
      (!$stable(last_time_ff)) |-> ($past(mul_done) || $past(reset)))
      else $error("stored time changed outside commit");
`endif

endmodule
